### design/interval_arithmetic_mod_q_unit_defines.svh
// Assertion macros for the interval unit checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef INTERVAL_ARITHMETIC_MOD_Q_UNIT_DEFINES_SVH
`define INTERVAL_ARITHMETIC_MOD_Q_UNIT_DEFINES_SVH

// Same-cycle implication.
`define IAMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IAMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/iamq_pkg.sv
// Package for the interval unit: opcodes, status codes, modulus constants
// and the residue helper functions. No dependencies.
`timescale 1ns / 1ps

package iamq_pkg;

  typedef enum logic [2:0] {
    OP_CHECK  = 3'd0,
    OP_NEGATE = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_REDUCE = 3'd4,
    OP_INV3   = 3'd5,
    OP_SHIFT  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_BAD = 2'd2
  } sts_e;

  localparam int unsigned ModQ   = 12289;
  localparam int unsigned ModQm1 = 12288;
  localparam int unsigned HalfQ  = 6144;
  localparam int unsigned Inv3Q  = 8193;

  // 2^16k mod Q for the chunk fold
  localparam int unsigned R16 = 65536 % ModQ;
  localparam int unsigned R32 = (R16 * R16) % ModQ;
  localparam int unsigned R48 = (R32 * R16) % ModQ;

  // floor(2^45 / Q) for the reciprocal estimate
  localparam int unsigned RecipShift = 45;
  localparam longint unsigned RecipQ = (64'd1 << RecipShift) / ModQ;

  localparam int unsigned QeW  = 19;
  localparam int unsigned ResW = 14;

  typedef struct packed {
    op_e         op;
    sts_e        sts;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        full;
  } ctl_t;

  // Quotient estimate for v / Q, low by at most one.
  function automatic logic [QeW-1:0] modq_est(input logic [31:0] v);
    logic [63:0] p;
    p = {32'd0, v} * {32'd0, RecipQ[31:0]};
    return p[63:RecipShift];
  endfunction

  // Remainder from the estimate, with one correction step.
  function automatic logic [ResW-1:0] modq_fix(input logic [31:0] v,
                                               input logic [QeW-1:0] qe);
    logic [32:0] r;
    r = {1'b0, v} - (33'(qe) * 33'(ModQ));
    if (r >= 33'(ModQ)) begin
      r = r - 33'(ModQ);
    end
    return r[ResW-1:0];
  endfunction

endpackage

### design/iamq_in_if.sv
// Input channel of the interval unit: valid/ready and one operation item.
// Depends on nothing.
`timescale 1ns / 1ps

interface iamq_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  cmd;
  logic signed [63:0] a_low;
  logic signed [63:0] a_high;
  logic signed [63:0] b_low;
  logic signed [63:0] b_high;

  modport source (output valid, cmd, a_low, a_high, b_low, b_high, input ready);
  modport sink   (input valid, cmd, a_low, a_high, b_low, b_high, output ready);
endinterface

### design/iamq_out_if.sv
// Output channel of the interval unit: valid/ready and one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface iamq_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] res_low;
  logic signed [63:0] res_high;
  logic        [1:0]  status;

  modport source (output valid, res_low, res_high, status, input ready);
  modport sink   (input valid, res_low, res_high, status, output ready);
endinterface

### design/interval_arithmetic_mod_q_unit.sv
// Interval arithmetic unit over signed 64-bit intervals with reduction mod 12289.
// Depends on iamq_pkg, iamq_in_if and iamq_out_if.
`timescale 1ns / 1ps

// One item enters per clock unless the output stalls; its result passes six
// pipeline stages and the output register. The pipeline advances whenever
// the output register is empty or being taken, so a stall at the output
// freezes every stage and a waiting result never blocks a new item beyond
// that. Residues mod 12289 fold the 64-bit operand in 16-bit chunks, then
// use a 32x32 reciprocal multiply and one correction; that multiply sets
// the stage depth, and the inverse-of-3 step reuses the same scheme.
module interval_arithmetic_mod_q_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  iamq_in_if.sink     in_i,
  iamq_out_if.source  out_o
);
  import iamq_pkg::*;

  localparam int unsigned NumCtl = 6;

  logic              adv;
  logic [NumCtl-1:0] v_q;
  ctl_t              ctl_d;
  ctl_t              ctl_q [NumCtl];

  logic [15:0]       c0_d   [2];
  logic [31:0]       p_d    [2][3];
  logic              neg_d  [2];
  logic [15:0]       c0_q   [2];
  logic [31:0]       p_q    [2][3];
  logic              neg0_q [2];
  logic              neg1_q [2];
  logic              neg2_q [2];
  logic [31:0]       s1_q   [2];
  logic [31:0]       s2_q   [2];
  logic [QeW-1:0]    qe_q   [2];
  logic [ResW-1:0]   r3_q   [2];
  logic [ResW-1:0]   r4_q   [2];
  logic [ResW-1:0]   r5_q   [2];
  logic [26:0]       t4_q;
  logic [26:0]       t5_q;
  logic [QeW-1:0]    q5_q;

  logic              out_valid_q;
  logic [63:0]       out_lo_d, out_hi_d, out_lo_q, out_hi_q;
  sts_e              out_sts_q;
  logic [ResW-1:0]   inv_r;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 0: decode, interval arithmetic, chunk products
  always_comb begin
    logic [63:0] al, ah, bl, bh, sum_lo, sum_hi, u;
    al = in_i.a_low;
    ah = in_i.a_high;
    bl = in_i.b_low;
    bh = in_i.b_high;
    sum_lo = '0;
    sum_hi = '0;
    ctl_d.op   = op_e'(in_i.cmd);
    ctl_d.sts  = ST_OK;
    ctl_d.lo   = '0;
    ctl_d.hi   = '0;
    ctl_d.full = 1'b0;
    case (op_e'(in_i.cmd))
      OP_CHECK: begin
        ctl_d.lo = al;
        ctl_d.hi = ah;
      end
      OP_NEGATE: begin
        if (al == {1'b1, 63'd0}) begin
          ctl_d.sts = ST_OVF;
        end else begin
          ctl_d.lo = 64'd0 - ah;
          ctl_d.hi = 64'd0 - al;
        end
      end
      OP_ADD: begin
        sum_lo = al + bl;
        sum_hi = ah + bh;
        if ($signed(bl) > $signed(bh)) begin
          ctl_d.sts = ST_BAD;
        end else if (((al[63] == bl[63]) && (sum_lo[63] != al[63])) ||
                     ((ah[63] == bh[63]) && (sum_hi[63] != ah[63]))) begin
          ctl_d.sts = ST_OVF;
        end else begin
          ctl_d.lo = sum_lo;
          ctl_d.hi = sum_hi;
        end
      end
      OP_SUB: begin
        sum_lo = al - bh;
        sum_hi = ah - bl;
        if ($signed(bl) > $signed(bh)) begin
          ctl_d.sts = ST_BAD;
        end else if (((al[63] != bh[63]) && (sum_lo[63] != al[63])) ||
                     ((ah[63] != bl[63]) && (sum_hi[63] != ah[63]))) begin
          ctl_d.sts = ST_OVF;
        end else begin
          ctl_d.lo = sum_lo;
          ctl_d.hi = sum_hi;
        end
      end
      OP_REDUCE: begin
        sum_lo     = ah - al;
        ctl_d.full = (sum_lo >= 64'(ModQm1));
      end
      OP_INV3: begin
        ctl_d.full = (al != ah);
      end
      OP_SHIFT: begin
        if (al[63] || ($signed(ah) > $signed(64'(ModQm1)))) begin
          ctl_d.sts = ST_BAD;
        end else if ($signed(al) > $signed(64'(HalfQ))) begin
          ctl_d.lo = al - 64'(ModQ);
          ctl_d.hi = ah - 64'(ModQ);
        end else if ($signed(ah) <= $signed(64'(HalfQ))) begin
          ctl_d.lo = al;
          ctl_d.hi = ah;
        end else begin
          ctl_d.lo = 64'd0 - 64'(HalfQ);
          ctl_d.hi = 64'(HalfQ);
        end
      end
      default: begin
        ctl_d.sts = ST_BAD;
      end
    endcase
    if ($signed(al) > $signed(ah)) begin
      ctl_d.sts = ST_BAD;
    end
    if (ctl_d.sts != ST_OK) begin
      ctl_d.lo = '0;
      ctl_d.hi = '0;
    end
    for (int l = 0; l < 2; l++) begin
      u = (l == 0) ? al : ah;
      neg_d[l] = u[63];
      if (u[63]) begin
        u = ~u;
      end
      c0_d[l]   = u[15:0];
      p_d[l][0] = {16'd0, u[31:16]} * R16;
      p_d[l][1] = {16'd0, u[47:32]} * R32;
      p_d[l][2] = {16'd0, u[63:48]} * R48;
    end
  end

  assign inv_r = modq_fix({5'd0, t5_q}, q5_q);

  // Output select
  always_comb begin
    out_lo_d = ctl_q[NumCtl-1].lo;
    out_hi_d = ctl_q[NumCtl-1].hi;
    if (ctl_q[NumCtl-1].sts == ST_OK) begin
      case (ctl_q[NumCtl-1].op)
        OP_REDUCE: begin
          if (ctl_q[NumCtl-1].full || (r5_q[0] > r5_q[1])) begin
            out_lo_d = '0;
            out_hi_d = 64'(ModQm1);
          end else begin
            out_lo_d = 64'(r5_q[0]);
            out_hi_d = 64'(r5_q[1]);
          end
        end
        OP_INV3: begin
          if (ctl_q[NumCtl-1].full) begin
            out_lo_d = '0;
            out_hi_d = 64'(ModQm1);
          end else begin
            out_lo_d = 64'(inv_r);
            out_hi_d = 64'(inv_r);
          end
        end
        default: begin
          out_lo_d = ctl_q[NumCtl-1].lo;
          out_hi_d = ctl_q[NumCtl-1].hi;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[NumCtl-2:0], in_i.valid};
      out_valid_q <= v_q[NumCtl-1];
    end
  end

  // Advance the datapath; hold everything on a stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < NumCtl; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      for (int l = 0; l < 2; l++) begin
        c0_q[l]   <= c0_d[l];
        p_q[l]    <= p_d[l];
        neg0_q[l] <= neg_d[l];
        s1_q[l]   <= {16'd0, c0_q[l]} + p_q[l][0] + p_q[l][1] + p_q[l][2];
        neg1_q[l] <= neg0_q[l];
        s2_q[l]   <= s1_q[l];
        qe_q[l]   <= modq_est(s1_q[l]);
        neg2_q[l] <= neg1_q[l];
        r3_q[l]   <= neg2_q[l] ? ResW'(ModQm1) - modq_fix(s2_q[l], qe_q[l])
                               : modq_fix(s2_q[l], qe_q[l]);
        r4_q[l]   <= r3_q[l];
        r5_q[l]   <= r4_q[l];
      end
      t4_q      <= 27'({13'd0, r3_q[0]} * 27'(Inv3Q));
      t5_q      <= t4_q;
      q5_q      <= modq_est({5'd0, t4_q});
      out_lo_q  <= out_lo_d;
      out_hi_q  <= out_hi_d;
      out_sts_q <= ctl_q[NumCtl-1].sts;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.res_low  = out_lo_q;
  assign out_o.res_high = out_hi_q;
  assign out_o.status   = out_sts_q;

endmodule

### design/iamq_chk.sv
// Port-level checks for the interval unit, bound to the top level.
// Depends on iamq_pkg and interval_arithmetic_mod_q_unit_defines.svh.
`timescale 1ns / 1ps
`include "interval_arithmetic_mod_q_unit_defines.svh"

module iamq_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [63:0] res_low_i,
  input logic signed [63:0] res_high_i,
  input logic        [1:0]  status_i
);
  import iamq_pkg::*;

  logic         out_stall;
  logic         err_item;
  logic         ok_item;
  logic         res_zero;
  logic [129:0] res_bits;

  assign out_stall = out_valid_i && !out_ready_i;
  assign err_item  = out_valid_i && (status_i != ST_OK);
  assign ok_item   = out_valid_i && (status_i == ST_OK);
  assign res_zero  = (res_low_i == 64'sd0) && (res_high_i == 64'sd0);
  assign res_bits  = {res_low_i, res_high_i, status_i};

  `IAMQ_ASSERT_IMP(a_ready_only_on_stall, !in_ready_i, out_stall, "input held without a stall")
  `IAMQ_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(res_bits), "stalled item changed")
  `IAMQ_ASSERT_IMP(a_err_zero, err_item, res_zero, "error item carries bounds")
  `IAMQ_ASSERT_IMP(a_ok_ordered, ok_item, res_low_i <= res_high_i, "result interval inverted")

endmodule

bind interval_arithmetic_mod_q_unit iamq_chk u_iamq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res_low_i   (out_o.res_low),
  .res_high_i  (out_o.res_high),
  .status_i    (out_o.status)
);
